>>> design/u16u8_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// No dependencies; used by u16u8_encode and utf16_to_utf8_encoder.
package u16u8_pkg;

    // Most bytes one item can produce: a 3-byte flush plus a 3-byte unit.
    localparam int MaxBytes = 6;
    localparam int CntW     = 3;

    // Surrogate prefixes, taken from the top six bits of the code unit.
    localparam logic [5:0] HighPrefix = 6'b110110;  // 0xD800..0xDBFF
    localparam logic [5:0] LowPrefix  = 6'b110111;  // 0xDC00..0xDFFF

    localparam logic [15:0] OneByteMax = 16'h007F;
    localparam logic [15:0] TwoByteMax = 16'h07FF;
    localparam logic [20:0] SuppBase   = 21'h10000;

    localparam logic [7:0] LeadTwo   = 8'hC0;
    localparam logic [7:0] LeadThree = 8'hE0;
    localparam logic [7:0] LeadFour  = 8'hF0;
    localparam logic [7:0] ContByte  = 8'h80;

    typedef logic [CntW-1:0] t_cnt;
    typedef logic [MaxBytes-1:0][7:0] t_byte_vec;

    // Result of encoding one item against the held surrogate.
    typedef struct packed {
        t_byte_vec   bytes;
        t_cnt        cnt;
        logic        held_valid;
        logic [9:0]  held_bits;
    } t_enc;

endpackage

>>> design/utf16_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder: byte buffer, surrogate hold,
// handshakes. Depends on u16u8_pkg and u16u8_encode.
//
// Each accepted item is one UTF-16 code unit with an end-of-string flag. The
// block emits one UTF-8 byte per cycle while the receiver does not stall.
// An item yields nothing for a high surrogate that is held, one to three
// bytes for a plain unit, four for a completed surrogate pair and up to six
// when a held high surrogate that is not followed by a low one is flushed
// as three bytes ahead of the current unit. The single byte-wide output
// port sets the pace of items. The next item is taken in the same cycle as
// the last byte of the previous one leaves, so a stream of ASCII flows at
// one item per cycle while the receiver does not stall.
// run_end marks the last byte of each item and string_end the last byte of
// an item flagged as the end of the string. A high surrogate that ends the
// string is flushed at once rather than held. Reset drops any held unit.
module utf16_to_utf8_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_code_unit,
    input  logic        i_end_of_string,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_end,
    output logic        o_string_end
);

    u16u8_pkg::t_enc      enc;
    u16u8_pkg::t_byte_vec r_bytes, n_bytes;
    u16u8_pkg::t_cnt      r_cnt, n_cnt;
    logic                 r_eos, n_eos;
    logic                 r_held_valid, n_held_valid;
    logic [9:0]           r_held_bits, n_held_bits;
    logic                 in_acc;
    logic                 out_acc;

    u16u8_encode u_encode (
        .i_code_unit     (i_code_unit),
        .i_end_of_string (i_end_of_string),
        .i_held_valid    (r_held_valid),
        .i_held_bits     (r_held_bits),
        .o_enc           (enc)
    );

    // Take a new item once the buffer is empty or its last byte leaves now.
    assign o_stall = (r_cnt > u16u8_pkg::t_cnt'(1))
                  || ((r_cnt == u16u8_pkg::t_cnt'(1)) && i_stall);
    assign in_acc  = i_valid && !o_stall;

    assign o_valid      = (r_cnt != '0);
    assign out_acc      = o_valid && !i_stall;
    assign o_out_byte   = r_bytes[0];
    assign o_run_end    = (r_cnt == u16u8_pkg::t_cnt'(1));
    assign o_string_end = (r_cnt == u16u8_pkg::t_cnt'(1)) && r_eos;

    always_comb begin
        n_bytes      = r_bytes;
        n_cnt        = r_cnt;
        n_eos        = r_eos;
        n_held_valid = r_held_valid;
        n_held_bits  = r_held_bits;
        if (in_acc) begin
            // Load the fresh bytes; any byte still buffered leaves this cycle.
            n_bytes      = enc.bytes;
            n_cnt        = enc.cnt;
            n_eos        = i_end_of_string;
            n_held_valid = enc.held_valid;
            n_held_bits  = enc.held_bits;
        end else if (out_acc) begin
            // Advance to the next byte.
            n_bytes = r_bytes >> 8;
            n_cnt   = r_cnt - u16u8_pkg::t_cnt'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_held_valid <= 1'b0;
            r_held_bits  <= '0;
        end else begin
            r_cnt        <= n_cnt;
            r_held_valid <= n_held_valid;
            r_held_bits  <= n_held_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bytes <= n_bytes;
        r_eos   <= n_eos;
    end

    // An item is only taken when no pending byte would be overwritten.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_cnt == '0) || ((r_cnt == u16u8_pkg::t_cnt'(1)) && out_acc))
        else $error("item accepted over pending bytes");

    // The buffer never claims more bytes than one item can yield.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= u16u8_pkg::t_cnt'(u16u8_pkg::MaxBytes))
        else $error("byte count out of range");

    // A surrogate is held only after accepting a high surrogate mid-string.
    a_hold_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_held_valid) |-> $past(in_acc && !i_end_of_string
            && (i_code_unit[15:10] == u16u8_pkg::HighPrefix)))
        else $error("surrogate held without a high surrogate item");

    // Holding a surrogate with no flush leaves nothing to send.
    a_hold_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !r_held_valid && enc.held_valid) |=> (r_cnt == '0))
        else $error("held surrogate produced bytes");

endmodule

>>> design/u16u8_encode.sv
// Combinational encoder: one UTF-16 unit plus held surrogate to UTF-8 bytes.
// Depends on u16u8_pkg.
module u16u8_encode (
    input  logic [15:0]      i_code_unit,
    input  logic             i_end_of_string,
    input  logic             i_held_valid,
    input  logic [9:0]       i_held_bits,
    output u16u8_pkg::t_enc  o_enc
);

    logic        is_high;
    logic        is_low;
    logic [20:0] cp;
    logic [15:0] held_unit;
    logic [2:0][7:0] ub;
    logic [2:0][7:0] fb;
    logic [1:0]  un;

    assign is_high   = (i_code_unit[15:10] == u16u8_pkg::HighPrefix);
    assign is_low    = (i_code_unit[15:10] == u16u8_pkg::LowPrefix);
    assign cp        = u16u8_pkg::SuppBase + {1'b0, i_held_bits, i_code_unit[9:0]};
    assign held_unit = {u16u8_pkg::HighPrefix, i_held_bits};

    // Bytes of the current unit on its own.
    always_comb begin
        ub = '0;
        if (i_code_unit <= u16u8_pkg::OneByteMax) begin
            ub[0] = i_code_unit[7:0];
            un    = 2'd1;
        end else if (i_code_unit <= u16u8_pkg::TwoByteMax) begin
            ub[0] = u16u8_pkg::LeadTwo  | {3'b000, i_code_unit[10:6]};
            ub[1] = u16u8_pkg::ContByte | {2'b00, i_code_unit[5:0]};
            un    = 2'd2;
        end else begin
            ub[0] = u16u8_pkg::LeadThree | {4'b0000, i_code_unit[15:12]};
            ub[1] = u16u8_pkg::ContByte  | {2'b00, i_code_unit[11:6]};
            ub[2] = u16u8_pkg::ContByte  | {2'b00, i_code_unit[5:0]};
            un    = 2'd3;
        end
    end

    // Flush bytes of the held high surrogate, always three.
    assign fb[0] = u16u8_pkg::LeadThree | {4'b0000, held_unit[15:12]};
    assign fb[1] = u16u8_pkg::ContByte  | {2'b00, held_unit[11:6]};
    assign fb[2] = u16u8_pkg::ContByte  | {2'b00, held_unit[5:0]};

    always_comb begin
        o_enc = '0;
        if (i_held_valid && is_low) begin
            // Complete pair: four-byte sequence, nothing held afterwards.
            o_enc.bytes[0] = u16u8_pkg::LeadFour | {5'b00000, cp[20:18]};
            o_enc.bytes[1] = u16u8_pkg::ContByte | {2'b00, cp[17:12]};
            o_enc.bytes[2] = u16u8_pkg::ContByte | {2'b00, cp[11:6]};
            o_enc.bytes[3] = u16u8_pkg::ContByte | {2'b00, cp[5:0]};
            o_enc.cnt      = u16u8_pkg::t_cnt'(4);
        end else begin
            if (i_held_valid) begin
                o_enc.bytes[0] = fb[0];
                o_enc.bytes[1] = fb[1];
                o_enc.bytes[2] = fb[2];
            end
            if (is_high && !i_end_of_string) begin
                // Hold the new high surrogate; only a flush, if any, goes out.
                o_enc.held_valid = 1'b1;
                o_enc.held_bits  = i_code_unit[9:0];
                o_enc.cnt        = i_held_valid ? u16u8_pkg::t_cnt'(3) : '0;
            end else if (i_held_valid) begin
                o_enc.bytes[3] = ub[0];
                o_enc.bytes[4] = ub[1];
                o_enc.bytes[5] = ub[2];
                o_enc.cnt      = u16u8_pkg::t_cnt'(3) + u16u8_pkg::t_cnt'(un);
            end else begin
                o_enc.bytes[0] = ub[0];
                o_enc.bytes[1] = ub[1];
                o_enc.bytes[2] = ub[2];
                o_enc.cnt      = u16u8_pkg::t_cnt'(un);
            end
        end
    end

endmodule

>>> dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for utf16_to_utf8_encoder: directed table, then random text.
// Depends on u16u8_pkg and the encoder RTL; checks every UTF-8 byte against typed bytes or a predictor.
module testbench;

    localparam int HalfPeriod  = 5;
    localparam int ResetCycles = 12;
    localparam int HoldCycles  = 200;   // long receiver hold-off
    localparam int DrainCycles = 16;    // extra wait past the last result
    localparam int QuietLimit  = 1000;  // cycles without any handshake
    localparam int RandomUnits = 100;
    localparam int ReportMax   = 10;
    localparam int NumDirected = 25;
    localparam int Predict     = -1;    // row carries no typed bytes

    // One UTF-8 byte as it leaves the block.
    typedef struct packed {
        logic [7:0] octet;
        logic       run_end;
        logic       string_end;
    } t_utf8_out;

    // One code unit to send; seq holds the typed bytes, first byte leftmost.
    typedef struct {
        logic [15:0] unit;
        logic        eos;
        int          nb;
        logic [47:0] seq;
    } t_unit_row;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic [15:0] i_code_unit     = 16'h0000;
    logic        i_end_of_string = 1'b0;
    logic        i_stall         = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_run_end;
    logic        o_string_end;

    // Directed table. The typed bytes cover reset state, range edges, every
    // surrogate case and the zero unit; the last rows go to the predictor.
    t_unit_row dir_rows [0:NumDirected-1] = '{
        '{16'h0041, 1'b0, 1, 48'h41},               // first unit after reset
        '{16'h0001, 1'b0, 1, 48'h01},
        '{16'h007F, 1'b0, 1, 48'h7F},               // top of one byte
        '{16'h0080, 1'b0, 2, 48'hC280},             // bottom of two bytes
        '{16'h07FF, 1'b0, 2, 48'hDFBF},
        '{16'h0800, 1'b0, 3, 48'hE0A080},           // bottom of three bytes
        '{16'hFFFF, 1'b1, 3, 48'hEFBFBF},           // all ones, ends string
        '{16'h0000, 1'b0, 1, 48'h00},               // zero unit
        '{16'hD800, 1'b0, 0, 48'h0},                // lowest high surrogate, held
        '{16'hDC00, 1'b0, 4, 48'hF0908080},         // lowest pair
        '{16'hDBFF, 1'b0, 0, 48'h0},
        '{16'hDFFF, 1'b1, 4, 48'hF48FBFBF},         // highest pair, ends string
        '{16'hDC00, 1'b0, 3, 48'hEDB080},           // lone low surrogate
        '{16'hD800, 1'b0, 0, 48'h0},
        '{16'h0041, 1'b0, 4, 48'hEDA08041},         // held one flushed before ASCII
        '{16'hDBFF, 1'b0, 0, 48'h0},
        '{16'hFFFF, 1'b0, 6, 48'hEDAFBFEFBFBF},     // flush plus three bytes
        '{16'hD800, 1'b0, 0, 48'h0},
        '{16'hDBFF, 1'b0, 3, 48'hEDA080},           // high after high: old one out
        '{16'hDFFF, 1'b0, 4, 48'hF48FBFBF},         // pairs with the newer high
        '{16'hDBFF, 1'b1, 3, 48'hEDAFBF},           // high surrogate ends string
        '{16'hD800, 1'b0, 0, 48'h0},
        '{16'h0080, 1'b1, 5, 48'hEDA080C280},       // flush, then end of string
        '{16'h1234, 1'b0, Predict, 48'h0},
        '{16'hABCD, 1'b1, Predict, 48'h0}
    };

    t_unit_row   unit_plan [$];     // everything the sender will offer
    t_utf8_out   utf8_due  [$];     // bytes still owed by the block
    logic [7:0]  utf8_seq  [$];     // bytes of the unit just predicted

    // Predictor state: the held high surrogate.
    logic        held_hi_valid = 1'b0;
    logic [9:0]  held_hi_bits  = 10'h000;

    int          err_cnt       = 0;
    int          bytes_checked = 0;
    int          units_sent    = 0;
    int          pairs_made    = 0;
    int          holdoffs      = 0;

    // Receiver and watchdog state; the receiver process owns all but hold_asks and quiet_cycles.
    int          hold_asks     = 0;   // bumped by the sender to ask for a hold-off
    int          hold_seen     = 0;
    int          stall_left    = 0;
    int          rx_cycles     = 0;
    logic        rx_calm       = 1'b0;
    int          quiet_cycles  = 0;

    utf16_to_utf8_encoder i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_code_unit    (i_code_unit),
        .i_end_of_string(i_end_of_string),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_run_end      (o_run_end),
        .o_string_end   (o_string_end)
    );

    always #HalfPeriod i_clk = ~i_clk;

    // Count a failure; report only the first ReportMax in full.
    function automatic void note_fail(input string msg);
        err_cnt++;
        if (err_cnt <= ReportMax) begin
            $display("error: %s", msg);
        end
    endfunction

    // Append the 1, 2 or 3 byte form of a single BMP unit.
    function automatic void emit_unit(input logic [15:0] u);
        if (u <= u16u8_pkg::OneByteMax) begin
            utf8_seq.push_back(u[7:0]);
        end else if (u <= u16u8_pkg::TwoByteMax) begin
            utf8_seq.push_back(u16u8_pkg::LeadTwo | {3'b000, u[10:6]});
            utf8_seq.push_back(u16u8_pkg::ContByte | {2'b00, u[5:0]});
        end else begin
            utf8_seq.push_back(u16u8_pkg::LeadThree | {4'h0, u[15:12]});
            utf8_seq.push_back(u16u8_pkg::ContByte | {2'b00, u[11:6]});
            utf8_seq.push_back(u16u8_pkg::ContByte | {2'b00, u[5:0]});
        end
    endfunction

    // Work out the bytes one accepted unit yields and advance the held state.
    function automatic void predict_utf8(input logic [15:0] u, input logic eos);
        logic        is_high;
        logic        is_low;
        logic [20:0] cp;
        is_high = (u[15:10] == u16u8_pkg::HighPrefix);
        is_low  = (u[15:10] == u16u8_pkg::LowPrefix);
        utf8_seq.delete();
        if (held_hi_valid && is_low) begin
            // Complete the pair as a supplementary code point.
            cp = u16u8_pkg::SuppBase + {1'b0, held_hi_bits, u[9:0]};
            held_hi_valid = 1'b0;
            held_hi_bits  = 10'h000;
            pairs_made++;
            utf8_seq.push_back(u16u8_pkg::LeadFour | {5'b00000, cp[20:18]});
            utf8_seq.push_back(u16u8_pkg::ContByte | {2'b00, cp[17:12]});
            utf8_seq.push_back(u16u8_pkg::ContByte | {2'b00, cp[11:6]});
            utf8_seq.push_back(u16u8_pkg::ContByte | {2'b00, cp[5:0]});
        end else begin
            // Flush an unpaired high surrogate ahead of the current unit.
            if (held_hi_valid) begin
                emit_unit({u16u8_pkg::HighPrefix, held_hi_bits});
                held_hi_valid = 1'b0;
                held_hi_bits  = 10'h000;
            end
            if (is_high && !eos) begin
                held_hi_valid = 1'b1;
                held_hi_bits  = u[9:0];
            end else begin
                emit_unit(u);
            end
        end
    endfunction

    // Queue the bytes of one unit, marking the last of them.
    function automatic void queue_due(input logic eos);
        logic last;
        for (int i = 0; i < utf8_seq.size(); i++) begin
            last = (i == utf8_seq.size() - 1);
            utf8_due.push_back('{utf8_seq[i], last, last && eos});
        end
    endfunction

    // Sender: build the plan, release reset, then walk the plan item by item.
    initial begin
        t_unit_row   row;
        logic [15:0] u;
        logic [15:0] hi;
        logic        eos;
        int          sel;
        int          n_rand;
        int          gap;
        int          hold_at;
        logic        tx_calm;

        foreach (dir_rows[i]) begin
            unit_plan.push_back(dir_rows[i]);
        end

        // Random text: mostly plain units and well-formed pairs, some stray
        // surrogates to break the pairing up.
        n_rand = 0;
        while (n_rand < RandomUnits) begin
            sel = $urandom_range(0, 99);
            eos = ($urandom_range(0, 7) == 0);
            if (sel < 25) begin
                u = 16'($urandom_range(1, 16'h007F));
            end else if (sel < 40) begin
                u = 16'($urandom_range(16'h0080, 16'h07FF));
            end else if (sel < 62) begin
                do begin
                    u = 16'($urandom_range(16'h0800, 16'hFFFF));
                end while (u[15:11] == 5'b11011);
            end else if (sel < 85) begin
                hi = 16'($urandom_range(16'hD800, 16'hDBFF));
                unit_plan.push_back('{hi, 1'b0, Predict, 48'h0});
                n_rand++;
                u = 16'($urandom_range(16'hDC00, 16'hDFFF));
            end else if (sel < 93) begin
                u = 16'($urandom_range(16'hD800, 16'hDBFF));
            end else begin
                u = 16'($urandom_range(16'hDC00, 16'hDFFF));
            end
            unit_plan.push_back('{u, eos, Predict, 48'h0});
            n_rand++;
        end

        hold_at = NumDirected + 30;
        tx_calm = 1'b0;

        repeat (ResetCycles) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < unit_plan.size(); k++) begin
            row = unit_plan[k];
            if (k % 16 == 0) begin
                tx_calm = ($urandom_range(0, 2) == 0);
            end

            if (k == NumDirected) begin
                // Pause until the table has fully drained before random text.
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (utf8_due.size() != 0) @(posedge i_clk);
                repeat (DrainCycles) @(posedge i_clk);
            end else if (k != 0 && !tx_calm && !(k >= hold_at && k < hold_at + 8)) begin
                sel = $urandom_range(0, 99);
                gap = (sel < 55) ? 0
                    : (sel < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
                if (gap > 0) begin
                    i_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end

            // Ask the receiver to hold off while items keep coming.
            if (k == hold_at) begin
                hold_asks <= hold_asks + 1;
            end

            i_valid         <= 1'b1;
            i_code_unit     <= row.unit;
            i_end_of_string <= row.eos;
            do @(posedge i_clk); while (o_stall);

            // Accepted at this edge: predict, then prefer the typed bytes.
            predict_utf8(row.unit, row.eos);
            if (row.nb != Predict) begin
                utf8_seq.delete();
                for (int i = 0; i < row.nb; i++) begin
                    utf8_seq.push_back(row.seq[8*(row.nb-1-i) +: 8]);
                end
            end
            queue_due(row.eos);
            units_sent++;
        end
        i_valid <= 1'b0;

        // Drain, then wait DrainCycles longer for any stray byte to show.
        while (utf8_due.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);

        $display("summary: %0d code units, %0d UTF-8 bytes checked, %0d surrogate pairs,",
                 units_sent, bytes_checked, pairs_made);
        $display("summary: %0d long hold-offs, %0d errors", holdoffs, err_cnt);
        if (err_cnt == 0 && utf8_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Receiver: check each accepted byte, then choose the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            bytes_checked++;
            if (utf8_due.size() == 0) begin
                note_fail($sformatf("unexpected byte %02h run_end %b string_end %b",
                                    o_out_byte, o_run_end, o_string_end));
            end else begin
                if (utf8_due[0] != t_utf8_out'{o_out_byte, o_run_end, o_string_end}) begin
                    note_fail($sformatf("byte %02h run_end %b string_end %b, expected %02h %b %b",
                                        o_out_byte, o_run_end, o_string_end, utf8_due[0].octet,
                                        utf8_due[0].run_end, utf8_due[0].string_end));
                end
                void'(utf8_due.pop_front());
            end
        end

        // Calm stretches alternate with stalling ones.
        rx_cycles++;
        if (rx_cycles % 64 == 0) begin
            rx_calm = ($urandom_range(0, 2) == 0);
        end

        if (hold_asks != hold_seen) begin
            hold_seen  = hold_asks;
            stall_left = HoldCycles;
            holdoffs++;
        end else if (stall_left == 0 && !rx_calm) begin
            sel_stall();
        end

        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Mostly no stall, some short ones, the odd long one.
    function automatic void sel_stall();
        int r;
        r = $urandom_range(0, 99);
        stall_left = (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 30);
    endfunction

    // Watchdog: end the run if no handshake happens for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QuietLimit) begin
            $display("watchdog: no handshake for %0d cycles, %0d bytes still owed",
                     quiet_cycles, utf8_due.size());
            $display("testbench: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
